// ===== rtl/pes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_pkg
// Shared types, widths and helpers for the shifted polynomial evaluator.
// ----------------------------------------------------------------------------
package pes_pkg;

	localparam int FRAC_BITS = 16;
	localparam int X_W       = 32;
	localparam int PM_W      = 63;             // power magnitude, up to 2^62
	localparam int TM_W      = 60;             // term magnitude, up to 2^59
	localparam int ACC_W     = 63;             // signed running sum
	localparam int SPLIT     = 32;             // partial product split point
	localparam int HI_W      = PM_W - SPLIT;
	localparam int PH_W      = HI_W + X_W;
	localparam int PP_W      = SPLIT + X_W;
	localparam int PROD_W    = PH_W + SPLIT + 1;
	localparam int POW_EXP   = 62;
	localparam int TERM_EXP  = 59;
	localparam int IDX_W     = 3;
	localparam int DEG_W     = 3;

	localparam logic [IDX_W-1:0] REG_DEGREE = 3'd6;
	localparam logic [IDX_W-1:0] REG_OFFSET = 3'd7;

	localparam logic [X_W-1:0] X_MAX = 32'h7fff_ffff;
	localparam logic [X_W-1:0] X_MIN = 32'h8000_0000;

	// word passed from one power/term step to the next
	typedef struct packed {
		logic             valid;
		logic [PM_W-1:0]  pm;
		logic             pneg;
		logic             psat;
		logic [X_W-1:0]   xm;
		logic             xneg;
		logic [ACC_W-1:0] acc;
		logic             ovf;
		logic [TM_W-1:0]  tm;      // pending term, zero when unused
		logic             tneg;
		logic             tflag;
	} step_t;

	typedef struct packed {
		logic [PM_W-1:0] mag;
		logic            sat;
	} mag_t;

	// (hi_pp * 2^SPLIT + lo_pp) >> FRAC_BITS, clamped to 2^lim_exp
	function automatic mag_t mul_combine(input logic [PH_W-1:0] hi_pp,
			input logic [PP_W-1:0] lo_pp, input int lim_exp);
		logic [PROD_W-1:0] prod;
		logic [PROD_W-1:0] q;
		logic [PROD_W-1:0] lim;
		mag_t              r;
		prod = PROD_W'({hi_pp, {SPLIT{1'b0}}}) + PROD_W'(lo_pp);
		q    = prod >> FRAC_BITS;
		lim  = PROD_W'(1) << lim_exp;
		if (q > lim) begin
			r.mag = lim[PM_W-1:0];
			r.sat = 1'b1;
		end else begin
			r.mag = q[PM_W-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/pes_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_cfg
// Configuration registers: coefficients kept as magnitude and sign, the
// clamped degree and the x offset.
// ----------------------------------------------------------------------------
module pes_cfg #(
	parameter int MAX_DEGREE = 5
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [pes_pkg::IDX_W-1:0]                  cfg_index,
	input  logic [pes_pkg::X_W-1:0]                    cfg_data,
	output logic [MAX_DEGREE:0][pes_pkg::X_W-1:0]      coef_mag,
	output logic [MAX_DEGREE:0]                        coef_neg,
	output logic [pes_pkg::DEG_W-1:0]                  deg_eff,
	output logic [pes_pkg::X_W-1:0]                    x_offset
);

	localparam int X_W   = pes_pkg::X_W;
	localparam int DEG_W = pes_pkg::DEG_W;
	localparam int IDX_W = pes_pkg::IDX_W;

	logic [MAX_DEGREE:0][X_W-1:0] coef_mag_q;
	logic [MAX_DEGREE:0]          coef_neg_q;
	logic [DEG_W-1:0]             degree_q;
	logic [X_W-1:0]               offset_q;
	logic                         wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid & cfg_ready;

	for (genvar i = 0; i <= MAX_DEGREE; i++) begin : g_coef
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				coef_mag_q[i] <= '0;
				coef_neg_q[i] <= 1'b0;
			end else if (wr_en && cfg_index == IDX_W'(i)) begin
				coef_mag_q[i] <= cfg_data[X_W-1] ? (~cfg_data + 1'b1) : cfg_data;
				coef_neg_q[i] <= cfg_data[X_W-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			offset_q <= '0;
		end else if (wr_en) begin
			if (cfg_index == pes_pkg::REG_DEGREE) begin
				degree_q <= cfg_data[DEG_W-1:0];
			end
			if (cfg_index == pes_pkg::REG_OFFSET) begin
				offset_q <= cfg_data;
			end
		end
	end

	assign coef_mag = coef_mag_q;
	assign coef_neg = coef_neg_q;
	assign deg_eff  = (degree_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_q;
	assign x_offset = offset_q;

endmodule

// ===== rtl/pes_shift.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_shift
// Adds the offset to the sample, saturates, and forms the first power and
// the constant term for the step chain. Two stages.
// ----------------------------------------------------------------------------
module pes_shift (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [pes_pkg::X_W-1:0]  x_sample,
	input  logic [pes_pkg::X_W-1:0]  x_offset,
	input  logic [pes_pkg::X_W-1:0]  coef0_mag,
	input  logic                     coef0_neg,
	output pes_pkg::step_t           step_out
);

	localparam int X_W  = pes_pkg::X_W;
	localparam int PM_W = pes_pkg::PM_W;
	localparam int TM_W = pes_pkg::TM_W;

	logic           vld_s1;
	logic [X_W:0]   sum_s1;
	logic           x_ovf;
	logic           xneg;
	logic [X_W-1:0] xsat;
	logic [X_W-1:0] xm;
	pes_pkg::step_t out_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1 <= {x_sample[X_W-1], x_sample} + {x_offset[X_W-1], x_offset};
	end

	// 33-bit sum leaves the 32-bit range when its top two bits differ
	assign x_ovf = sum_s1[X_W] ^ sum_s1[X_W-1];
	assign xneg  = sum_s1[X_W];
	assign xsat  = x_ovf ? (xneg ? pes_pkg::X_MIN : pes_pkg::X_MAX) : sum_s1[X_W-1:0];
	assign xm    = xneg ? (~xsat + 1'b1) : xsat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s2 <= '0;
		end else begin
			out_s2.valid <= vld_s1;
			out_s2.pm    <= PM_W'(xm);
			out_s2.pneg  <= xneg;
			out_s2.psat  <= 1'b0;
			out_s2.xm    <= xm;
			out_s2.xneg  <= xneg;
			out_s2.acc   <= '0;
			out_s2.ovf   <= x_ovf;
			out_s2.tm    <= TM_W'(coef0_mag);
			out_s2.tneg  <= coef0_neg;
			out_s2.tflag <= 1'b0;
		end
	end

	assign step_out = out_s2;

endmodule

// ===== rtl/pes_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_step
// One power/term step: partial products of power*x and power*coef, then
// combine and clamp. The pending term of the previous step is folded into
// the running sum on the way in.
// ----------------------------------------------------------------------------
module pes_step #(
	parameter int IDX = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pes_pkg::step_t            step_in,
	input  logic [pes_pkg::X_W-1:0]   coef_mag,
	input  logic                      coef_neg,
	input  logic [pes_pkg::DEG_W-1:0] deg,
	output pes_pkg::step_t            step_out
);

	localparam int X_W   = pes_pkg::X_W;
	localparam int PM_W  = pes_pkg::PM_W;
	localparam int TM_W  = pes_pkg::TM_W;
	localparam int ACC_W = pes_pkg::ACC_W;
	localparam int PH_W  = pes_pkg::PH_W;
	localparam int PP_W  = pes_pkg::PP_W;
	localparam int SPLIT = pes_pkg::SPLIT;
	localparam int DEG_W = pes_pkg::DEG_W;

	logic             vld_s1;
	logic [PH_W-1:0]  pw_hi_s1;
	logic [PP_W-1:0]  pw_lo_s1;
	logic [PH_W-1:0]  tm_hi_s1;
	logic [PP_W-1:0]  tm_lo_s1;
	logic [ACC_W-1:0] acc_s1;
	logic             ovf_s1;
	logic [X_W-1:0]   xm_s1;
	logic             xneg_s1;
	logic             pneg_s1;
	logic             psat_s1;
	logic             use_s1;
	logic             tneg_s1;
	logic [ACC_W-1:0] acc_in;
	pes_pkg::mag_t    pw_res;
	pes_pkg::mag_t    tm_res;
	pes_pkg::step_t   out_s2;

	assign acc_in = step_in.tneg ? (step_in.acc - ACC_W'(step_in.tm))
	                             : (step_in.acc + ACC_W'(step_in.tm));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= step_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		pw_hi_s1 <= PH_W'(step_in.pm[PM_W-1:SPLIT]) * PH_W'(step_in.xm);
		pw_lo_s1 <= PP_W'(step_in.pm[SPLIT-1:0]) * PP_W'(step_in.xm);
		tm_hi_s1 <= PH_W'(step_in.pm[PM_W-1:SPLIT]) * PH_W'(coef_mag);
		tm_lo_s1 <= PP_W'(step_in.pm[SPLIT-1:0]) * PP_W'(coef_mag);
		acc_s1   <= acc_in;
		ovf_s1   <= step_in.ovf | step_in.tflag;
		xm_s1    <= step_in.xm;
		xneg_s1  <= step_in.xneg;
		pneg_s1  <= step_in.pneg;
		psat_s1  <= step_in.psat;
		use_s1   <= (|coef_mag) && (DEG_W'(IDX) <= deg);
		tneg_s1  <= coef_neg ^ step_in.pneg;
	end

	assign pw_res = pes_pkg::mul_combine(pw_hi_s1, pw_lo_s1, pes_pkg::POW_EXP);
	assign tm_res = pes_pkg::mul_combine(tm_hi_s1, tm_lo_s1, pes_pkg::TERM_EXP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s2 <= '0;
		end else begin
			out_s2.valid <= vld_s1;
			out_s2.pm    <= pw_res.mag;
			out_s2.pneg  <= pneg_s1 ^ xneg_s1;
			out_s2.psat  <= psat_s1 | pw_res.sat;
			out_s2.xm    <= xm_s1;
			out_s2.xneg  <= xneg_s1;
			out_s2.acc   <= acc_s1;
			out_s2.ovf   <= ovf_s1;
			out_s2.tm    <= use_s1 ? tm_res.mag[TM_W-1:0] : '0;
			out_s2.tneg  <= tneg_s1;
			// a clamped power taints every later term that is actually used
			out_s2.tflag <= use_s1 & (tm_res.sat | psat_s1);
		end
	end

	assign step_out = out_s2;

endmodule

// ===== rtl/polynomial_eval_shifted.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_eval_shifted
// Evaluates sum coef_i * (x + offset)^i in signed Q16.16, saturated to
// 32 bits with an overflow flag.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------
//   sample   | start, busy            | x_sample
//   result   | done (strobe)          | poly_value, overflow
//   config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// One sample per clock; busy stays low. A result passes through two shift
// stages, two stages per power step (partial products, then combine and
// clamp), a final add and a clamp.
// The result strobe cannot be held off and nothing in the pipe stalls.
// Reset empties the pipe and clears all configuration to zero.
// ----------------------------------------------------------------------------
module polynomial_eval_shifted #(
	parameter int MAX_DEGREE = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [pes_pkg::X_W-1:0]   x_sample,
	output logic                      done,
	output logic [pes_pkg::X_W-1:0]   poly_value,
	output logic                      overflow,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [pes_pkg::IDX_W-1:0] cfg_index,
	input  logic [pes_pkg::X_W-1:0]   cfg_data
);

	localparam int X_W   = pes_pkg::X_W;
	localparam int PM_W  = pes_pkg::PM_W;
	localparam int ACC_W = pes_pkg::ACC_W;
	localparam int DEG_W = pes_pkg::DEG_W;
	localparam int LAT   = 2 * MAX_DEGREE + 4;
	localparam logic [PM_W-1:0] POW_LIMIT = PM_W'(1) << pes_pkg::POW_EXP;

	logic [MAX_DEGREE:0][X_W-1:0] coef_mag;
	logic [MAX_DEGREE:0]          coef_neg;
	logic [DEG_W-1:0]             deg_eff;
	logic [X_W-1:0]               x_offset;
	logic                         accept;
	pes_pkg::step_t               chain [0:MAX_DEGREE];
	pes_pkg::step_t               last;

	logic             vld_s1;
	logic [ACC_W-1:0] sum_s1;
	logic             ovf_s1;
	logic             sat_pos;
	logic             sat_neg;
	logic             done_s2;
	logic [X_W-1:0]   value_s2;
	logic             ovf_s2;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	pes_cfg #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.coef_mag (coef_mag),
		.coef_neg (coef_neg),
		.deg_eff  (deg_eff),
		.x_offset (x_offset)
	);

	pes_shift u_shift (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.x_sample (x_sample),
		.x_offset (x_offset),
		.coef0_mag(coef_mag[0]),
		.coef0_neg(coef_neg[0]),
		.step_out (chain[0])
	);

	for (genvar k = 1; k <= MAX_DEGREE; k++) begin : g_step
		pes_step #(
			.IDX(k)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.step_in (chain[k-1]),
			.coef_mag(coef_mag[k]),
			.coef_neg(coef_neg[k]),
			.deg     (deg_eff),
			.step_out(chain[k])
		);
	end

	assign last = chain[MAX_DEGREE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1 <= last.tneg ? (last.acc - ACC_W'(last.tm)) : (last.acc + ACC_W'(last.tm));
		ovf_s1 <= last.ovf | last.tflag;
	end

	// fits in 32 bits only when bits [62:31] all agree
	assign sat_pos = ~sum_s1[ACC_W-1] & (|sum_s1[ACC_W-2:X_W-1]);
	assign sat_neg = sum_s1[ACC_W-1] & ~(&sum_s1[ACC_W-2:X_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2  <= 1'b0;
			value_s2 <= '0;
			ovf_s2   <= 1'b0;
		end else begin
			done_s2  <= vld_s1;
			value_s2 <= sat_pos ? pes_pkg::X_MAX :
			            sat_neg ? pes_pkg::X_MIN : sum_s1[X_W-1:0];
			ovf_s2   <= ovf_s1 | sat_pos | sat_neg;
		end
	end

	assign done       = done_s2;
	assign poly_value = value_s2;
	assign overflow   = ovf_s2;

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("sample did not produce a result on time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result word without a matching sample");

	a_pow_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(last.valid && last.psat) |-> (last.pm == POW_LIMIT))
		else $error("clamped power lost its limit value");
`endif

endmodule
